// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define CAMA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define CAMA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/cama_pkg.sv -----
// Shared constants and payload types of the circular arena block.
package cama_pkg;

    localparam int MEM_BYTES_DEF  = 4096;
    localparam int MAX_ACCESS_DEF = 4;
    localparam int WORD_W         = 32;
    localparam int CNT_W          = 3;
    localparam int ADDR_OUT_W     = 12;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [7:0] BYTE_MASK = 8'hff;

    typedef struct packed {
        logic                     opcode;
        logic signed [WORD_W-1:0] start_address;
        logic [CNT_W-1:0]         byte_count;
        logic signed [WORD_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [ADDR_OUT_W-1:0]    wrapped_address;
    } t_rsp;

endpackage

// ----- src/cama_req_if.sv -----
// Request channel: valid/ready handshake carrying one access.
interface cama_req_if import cama_pkg::*; ();
    logic valid;
    logic ready;
    t_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ----- src/cama_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one access result.
interface cama_rsp_if import cama_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp rsp;

    modport source (output valid, output rsp, input ready);
    modport sink   (input valid, input rsp, output ready);
endinterface

// ----- src/cama_ram.sv -----
// Generic single-port RAM with registered read data.
module cama_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ----- src/circular_arena_multibyte_access.sv -----
// One request at a time: a new request is taken only in the idle state, after the previous
//   result has been loaded into the output register. The single byte-wide RAM port moves
//   one byte per cycle. A memory size that is not a power of two adds the reciprocal
//   address remainder steps (S_MOD, S_FIX) to each request.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the RAM one byte a
//   cycle while the request channel is held not ready.
module circular_arena_multibyte_access import cama_pkg::*; #(
    parameter int MEM_BYTES        = MEM_BYTES_DEF,
    parameter int MAX_ACCESS_BYTES = MAX_ACCESS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cama_req_if.sink   i_req,
    cama_rsp_if.source o_rsp
);

    localparam int AW      = $clog2(MEM_BYTES);
    localparam int CW      = $clog2(MAX_ACCESS_BYTES + 1);
    localparam int STEP_W  = 2;
    localparam bit IS_POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
    // 2^32 mod MEM_BYTES: correction applied to negative start addresses
    localparam int unsigned TWO32_MOD = 32'((64'd1 << 32) % 64'(MEM_BYTES));
    localparam logic [AW-1:0] MEM_M1  = AW'(MEM_BYTES - 1);
    // floor(2^32 / MEM_BYTES): quotient estimate is at most one below the true one
    localparam logic [WORD_W-1:0] RECIP = WORD_W'((64'd1 << 32) / 64'(MEM_BYTES));
    localparam logic [WORD_W-1:0] MEM_W = WORD_W'(MEM_BYTES);

    // Sequencer codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_FIX   = 3'd3;
    localparam logic [2:0] S_PREP  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_READ  = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    // Remainder steps
    localparam logic [STEP_W-1:0] M_QUO  = 2'd0;
    localparam logic [STEP_W-1:0] M_PROD = 2'd1;
    localparam logic [STEP_W-1:0] M_DIFF = 2'd2;
    localparam logic [STEP_W-1:0] M_FOLD = 2'd3;

    // Control state
    logic [2:0]        r_state,     n_state;
    logic [AW-1:0]     r_addr,      n_addr;
    logic [CW-1:0]     r_left,      n_left;
    logic              r_rd_pend,   n_rd_pend;
    logic [STEP_W-1:0] r_step,      n_step;
    logic              r_out_valid, n_out_valid;

    // Datapath state
    logic                     r_op,    n_op;
    logic                     r_neg,   n_neg;
    logic [AW-1:0]            r_base,  n_base;
    logic [AW-1:0]            r_rem,   n_rem;
    logic [WORD_W-1:0]        r_div,   n_div;
    logic [WORD_W-1:0]        r_quo,   n_quo;
    logic [WORD_W-1:0]        r_acc,   n_acc;
    logic signed [WORD_W-1:0] r_wdata, n_wdata;
    t_rsp                     r_out,   n_out;

    // Shared arithmetic
    logic [WORD_W-1:0]   mul_a;
    logic [WORD_W-1:0]   mul_b;
    logic [2*WORD_W-1:0] mul_p;
    logic [WORD_W-1:0]   fold;
    logic [AW:0]         prep_sum;
    logic [AW-1:0]       addr_inc;
    logic [AW-1:0]       addr_dec;
    logic [CW-1:0]       req_cnt;

    // RAM port
    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.rsp   = r_out;

    assign addr_inc = (r_addr == MEM_M1) ? '0 : r_addr + 1'b1;
    assign addr_dec = (r_addr == '0) ? MEM_M1 : r_addr - 1'b1;

    // Saturate the byte count at the widest supported access
    assign req_cnt = (32'(i_req.req.byte_count) > MAX_ACCESS_BYTES)
                   ? CW'(MAX_ACCESS_BYTES) : CW'(i_req.req.byte_count);

    // One multiplier, shared: address times reciprocal, then quotient times size
    assign mul_a = (r_step == M_QUO) ? r_div : r_quo;
    assign mul_b = (r_step == M_QUO) ? RECIP : MEM_W;
    assign mul_p = (2*WORD_W)'(mul_a) * (2*WORD_W)'(mul_b);

    // Partial remainder is below twice the size: one subtract folds it into range
    assign fold = (r_quo >= MEM_W) ? r_quo - MEM_W : r_quo;

    // Last byte address of a write, before wrapping
    assign prep_sum = {1'b0, r_base} + (AW+1)'(r_left - CW'(1));

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_left      = r_left;
        n_rd_pend   = r_rd_pend;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_op        = r_op;
        n_neg       = r_neg;
        n_base      = r_base;
        n_rem       = r_rem;
        n_div       = r_div;
        n_quo       = r_quo;
        n_acc       = r_acc;
        n_wdata     = r_wdata;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_wdata   = '0;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep the RAM with zeros, one byte per cycle
                ram_we = 1'b1;
                n_addr = addr_inc;
                if (r_addr == MEM_M1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.req.opcode;
                    n_left    = req_cnt;
                    n_wdata   = i_req.req.write_value;
                    n_div     = i_req.req.start_address;
                    n_neg     = i_req.req.start_address[WORD_W-1];
                    n_rem     = '0;
                    n_step    = M_QUO;
                    if (IS_POW2) begin
                        // Two's complement low bits already give the true modulo
                        n_base  = i_req.req.start_address[AW-1:0];
                        n_state = S_PREP;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // Estimate the quotient, multiply back, subtract, fold once
                n_step = r_step + 1'b1;
                if (r_step == M_QUO) begin
                    n_quo = mul_p[2*WORD_W-1:WORD_W];
                end else if (r_step == M_PROD) begin
                    n_quo = mul_p[WORD_W-1:0];
                end else if (r_step == M_DIFF) begin
                    n_quo = r_div - r_quo;
                end else begin
                    n_quo   = fold;
                    n_rem   = AW'(fold);
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // Negative address: remove 2^32 mod size, fold back into range
                if (!r_neg) begin
                    n_base = r_rem;
                end else if (r_rem >= AW'(TWO32_MOD)) begin
                    n_base = r_rem - AW'(TWO32_MOD);
                end else begin
                    n_base = AW'({1'b0, r_rem} + (AW+1)'(MEM_BYTES - TWO32_MOD));
                end
                n_state = S_PREP;
            end
            S_PREP: begin
                n_acc     = '0;
                n_rd_pend = 1'b0;
                if (r_left == '0) begin
                    n_state = S_RESP;
                end else if (r_op == OP_WRITE) begin
                    // Write from the last byte backward: low byte first
                    if (prep_sum >= (AW+1)'(MEM_BYTES)) begin
                        n_addr = AW'(prep_sum - (AW+1)'(MEM_BYTES));
                    end else begin
                        n_addr = AW'(prep_sum);
                    end
                    n_state = S_WRITE;
                end else begin
                    n_addr  = r_base;
                    n_state = S_READ;
                end
            end
            S_WRITE: begin
                // Bytes past the word come from its sign extension
                ram_we    = 1'b1;
                ram_wdata = r_wdata[7:0] & BYTE_MASK;
                n_wdata   = r_wdata >>> 8;
                n_addr    = addr_dec;
                n_left    = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = S_RESP;
                end
            end
            S_READ: begin
                // Issue one address per cycle; collect its data from the registered RAM output in the next cycle
                if (r_left != '0) begin
                    n_addr    = addr_inc;
                    n_left    = r_left - 1'b1;
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                end
                if (r_rd_pend) begin
                    n_acc = {r_acc[WORD_W-9:0], ram_rdata};
                end
                if (r_left == '0 && r_rd_pend) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                // Hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out.read_value      = (r_op == OP_WRITE) ? '0 : r_acc;
                    n_out.wrapped_address = ADDR_OUT_W'(r_base);
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_left      <= n_left;
            r_rd_pend   <= n_rd_pend;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_neg   <= n_neg;
        r_base  <= n_base;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_quo   <= n_quo;
        r_acc   <= n_acc;
        r_wdata <= n_wdata;
        r_out   <= n_out;
    end

    cama_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_cama_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

// ----- src/cama_checker.sv -----
// Port-level checker for the circular arena block, bound to the top level.
`include "assert_macros.svh"

module cama_checker import cama_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input t_rsp o_rsp_rsp
);

    logic       req_fire;
    logic       rsp_fire;
    logic [1:0] r_outstanding, n_outstanding;

    assign req_fire = i_req_valid && i_req_ready;
    assign rsp_fire = o_rsp_valid && o_rsp_ready;

    always_comb begin
        n_outstanding = r_outstanding;
        if (req_fire && !rsp_fire) begin
            n_outstanding = r_outstanding + 1'b1;
        end else if (rsp_fire && !req_fire) begin
            n_outstanding = r_outstanding - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    `CAMA_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !(o_rsp_valid || i_req_ready), "ports not quiet after reset")
    `CAMA_ASSERT(a_busy_after_req, i_clk, i_rst_n, req_fire |=> !i_req_ready, "request taken while busy")
    `CAMA_ASSERT(a_rsp_has_req, i_clk, i_rst_n, o_rsp_valid |-> r_outstanding != 2'd0, "response without request")
    `CAMA_ASSERT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_rsp), "stalled response changed")
    `CAMA_ASSERT(a_addr_range, i_clk, i_rst_n, o_rsp_valid |-> 32'(o_rsp_rsp.wrapped_address) < MEM_BYTES, "wrapped address out of range")

endmodule

bind circular_arena_multibyte_access cama_checker #(
    .MEM_BYTES (MEM_BYTES)
) u_cama_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_rsp_rsp   (o_rsp.rsp)
);

// ----- tb/sv/circular_arena_multibyte_access_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the circular arena block: directed and random byte accesses.
module circular_arena_multibyte_access_tb;
    import cama_pkg::*;

    localparam int ARENA_BYTES   = MEM_BYTES_DEF;
    localparam int ACCESS_LIMIT  = MAX_ACCESS_DEF;
    // Covers the clearing pass after reset plus several times the slowest run.
    localparam int CYCLE_LIMIT   = 200000;
    // Give stray results plenty of room to show after the drain.
    localparam int SETTLE_CYCLES = 32;
    localparam int PRINT_LIMIT   = 40;

    logic i_clk;
    logic i_rst_n;

    cama_req_if req_ch ();
    cama_rsp_if rsp_ch ();

    circular_arena_multibyte_access #(
        .MEM_BYTES        (ARENA_BYTES),
        .MAX_ACCESS_BYTES (ACCESS_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the arena, updated as each request is accepted.
    logic [7:0] arena_model [ARENA_BYTES];
    // Results still owed by the block, oldest first.
    t_rsp       due_rsps [$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 1;

    // Receiver stall pattern state.
    int         sink_mode    = 0;
    int         sink_span    = 0;
    int         sink_tick    = 0;
    logic [7:0] sink_pattern = 8'hff;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: end the run as a failure when the cycle counter reaches CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Compute the result of one access and apply its writes to the shadow arena.
    function automatic t_rsp model_access(input t_req r);
        longint      signed_addr;
        longint      base;
        int          n;
        int          idx;
        logic [63:0] wide_value;
        logic [63:0] gathered;
        t_rsp        o;
        signed_addr = longint'(r.start_address);
        // True modulo: fold negative remainders back into the arena.
        base = signed_addr % ARENA_BYTES;
        if (base < 0)
            base += ARENA_BYTES;
        // Saturate over-long counts; a zero count touches nothing.
        n = (r.byte_count > ACCESS_LIMIT) ? ACCESS_LIMIT : int'(r.byte_count);
        wide_value = {{32{r.write_value[WORD_W-1]}}, r.write_value};
        gathered   = '0;
        for (int i = 0; i < n; i++) begin
            idx = int'((base + i) % ARENA_BYTES);
            if (r.opcode == OP_WRITE)
                arena_model[idx] = wide_value[8*(n-i-1) +: 8];
            else
                gathered = {gathered[55:0], arena_model[idx]};
        end
        o.read_value      = (r.opcode == OP_WRITE) ? '0 : gathered[WORD_W-1:0];
        o.wrapped_address = base[ADDR_OUT_W-1:0];
        return o;
    endfunction

    function automatic t_req make_access(input logic op, input logic [31:0] addr,
                                         input logic [CNT_W-1:0] count,
                                         input logic [31:0] value);
        t_req r;
        r.opcode        = op;
        r.start_address = addr;
        r.byte_count    = count;
        r.write_value   = value;
        return r;
    endfunction

    // Keep the upper address bits random and, three times in four, crowd the low bits into a few hot
    // spots, so reads land on bytes that earlier writes filled in.
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        a = $urandom;
        case ($urandom_range(0, 3))
            0: ;
            1: a[ADDR_OUT_W-1:0] = ADDR_OUT_W'($urandom_range(0, 31));
            2: a[ADDR_OUT_W-1:0] = ADDR_OUT_W'(ARENA_BYTES - 1 - $urandom_range(0, 15));
            default: a[ADDR_OUT_W-1:0] = ADDR_OUT_W'($urandom_range(0, 255));
        endcase
        return a;
    endfunction

    // Mostly legal counts 1..4; now and then zero or a count that saturates.
    function automatic logic [CNT_W-1:0] pick_count();
        int n;
        n = $urandom_range(0, 15);
        if (n < 12)
            return CNT_W'(1 + n % 4);
        else if (n == 12)
            return '0;
        else
            return CNT_W'(n - 8);
    endfunction

    // Offer one request, hold it until accepted, record its result, then
    // possibly drop valid for a random gap at the end of a burst.
    task automatic send_access(input t_req r);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.req   <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        due_rsps.push_back(model_access(r));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Check each accepted result against the oldest one owed, then pick the
    // next cycle's ready from the current stall pattern.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (due_rsps.size() == 0) begin
                flag_mismatch($sformatf("unexpected result, address %0d value %h",
                                        rsp_ch.rsp.wrapped_address, rsp_ch.rsp.read_value));
            end else begin
                want = due_rsps.pop_front();
                if (rsp_ch.rsp.read_value !== want.read_value)
                    flag_mismatch($sformatf("read_value %h, expected %h",
                                            rsp_ch.rsp.read_value, want.read_value));
                if (rsp_ch.rsp.wrapped_address !== want.wrapped_address)
                    flag_mismatch($sformatf("wrapped_address %0d, expected %0d",
                                            rsp_ch.rsp.wrapped_address, want.wrapped_address));
            end
        end
        // Switch between always ready, coin-flip stalls and a repeating on/off mask.
        if (sink_span == 0) begin
            sink_mode    = $urandom_range(0, 2);
            sink_span    = $urandom_range(50, 300);
            sink_pattern = 8'($urandom_range(1, 255));
        end
        sink_span--;
        sink_tick++;
        case (sink_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= sink_pattern[sink_tick % 8];
        endcase
    end

    // Extremes of address and value, zero and saturated counts, and accesses
    // that run off the top of the arena back to address zero.
    task automatic test_directed();
        send_access(make_access(OP_WRITE, 32'd0,        3'd4, 32'h1122_3344));
        send_access(make_access(OP_READ,  32'd0,        3'd4, 32'h0));
        send_access(make_access(OP_READ,  32'd4096,     3'd4, 32'hffff_ffff));
        send_access(make_access(OP_READ,  -32'sd4096,   3'd2, 32'h0));
        send_access(make_access(OP_WRITE, 32'd4094,     3'd4, 32'ha1b2_c3d4));
        send_access(make_access(OP_READ,  -32'sd2,      3'd4, 32'h0));
        send_access(make_access(OP_READ,  32'd0,        3'd4, 32'h0));
        send_access(make_access(OP_WRITE, 32'h8000_0000, 3'd1, 32'hffff_ff80));
        send_access(make_access(OP_READ,  32'h8000_0000, 3'd1, 32'h0));
        send_access(make_access(OP_WRITE, 32'd5,        3'd0, 32'hffff_ffff));
        send_access(make_access(OP_READ,  32'd4,        3'd4, 32'h0));
        send_access(make_access(OP_READ,  32'd0,        3'd0, 32'h0));
        send_access(make_access(OP_WRITE, 32'h7fff_ffff, 3'd7, 32'h8000_0000));
        send_access(make_access(OP_READ,  -32'sd1,      3'd5, 32'h0));
        send_access(make_access(OP_READ,  -32'sd4097,   3'd6, 32'h0));
        send_access(make_access(OP_WRITE, 32'h8000_0001, 3'd3, 32'h7fff_ffff));
        send_access(make_access(OP_READ,  32'h8000_0000, 3'd4, 32'h0));
        send_access(make_access(OP_READ,  32'h8000_0001, 3'd3, 32'h0));
        send_access(make_access(OP_WRITE, 32'd12345,    3'd2, 32'h0));
        send_access(make_access(OP_READ,  32'd12344,    3'd4, 32'h0));
        send_access(make_access(OP_WRITE, 32'hffff_f000, 3'd4, 32'h0000_0000));
        send_access(make_access(OP_READ,  32'd0,        3'd4, 32'h0));
    endtask

    // Free mix of reads and writes over the hot spots and the full address range.
    task automatic test_random_access();
        repeat (200)
            send_access(make_access(1'($urandom_range(0, 1)), pick_address(),
                                    pick_count(), $urandom));
    endtask

    // Write then read back the same bytes; now and then shift the read so the
    // pair no longer lines up.
    task automatic test_write_read_pairs();
        logic [31:0]      addr;
        logic [CNT_W-1:0] count;
        repeat (100) begin
            addr  = pick_address();
            count = pick_count();
            send_access(make_access(OP_WRITE, addr, count, $urandom));
            if ($urandom_range(0, 7) == 0)
                addr = addr + 32'($urandom_range(1, 3));
            send_access(make_access(OP_READ, addr, count, $urandom));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req   = '0;
        rsp_ch.ready = 1'b0;
        foreach (arena_model[k])
            arena_model[k] = 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_access();
        test_write_read_pairs();
        req_ch.valid <= 1'b0;

        // Drain every owed result, then watch a little longer for strays.
        while (due_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
